// ----- rtl/sorted_priority_list_macros.svh -----
// Assertion macros for the sorted priority list.
// Every property is clocked on the rising edge and is disabled while reset is asserted.
`ifndef SORTED_PRIORITY_LIST_MACROS_SVH
`define SORTED_PRIORITY_LIST_MACROS_SVH
`ifndef SYNTHESIS
`define SPL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SPL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/spl_pkg.sv -----
package spl_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int HANDLE_W     = 16;
  localparam int TAG_W        = 32;
  localparam int PRIO_W       = 32;
  localparam int RANK_W       = 8;
  localparam int COUNT_OUT_W  = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_MISS  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    tag;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;     // register the compare flags
    logic ins_go;     // commit an insert
    logic rem_go;     // commit a remove
    logic bus_load;   // copy entries onto the read-out bus
    logic bus_shift;  // advance the read-out bus one cell toward the head
  } cell_ctl_t;

endpackage

// ----- rtl/spl_cell.sv -----
module spl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 9
) (
  input  logic              clk,
  input  spl_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]  count,
  input  spl_pkg::entry_t   new_entry,
  input  spl_pkg::entry_t   prev_entry,
  input  spl_pkg::entry_t   next_entry,
  input  logic              prev_take,
  input  logic              pre_hit,
  input  spl_pkg::entry_t   next_bus,
  output spl_pkg::entry_t   entry,
  output logic              take,
  output logic              match,
  output spl_pkg::entry_t   bus
);

  spl_pkg::entry_t entry_r, entry_nxt;
  spl_pkg::entry_t bus_r, bus_nxt;
  logic            take_r, take_nxt;
  logic            match_r, match_nxt;
  logic            occ;

  always_comb begin
    occ       = CNT_W'(IDX) < count;
    // unoccupied cells always take, so the take flags rise once and stay up
    take_nxt  = !occ || ($signed(entry_r.prio) <= $signed(new_entry.prio));
    match_nxt = occ && (entry_r.handle == new_entry.handle) && (entry_r.tag == new_entry.tag);
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_go) begin
      if (prev_take) begin
        entry_nxt = prev_entry;
      end else if (take_r) begin
        entry_nxt = new_entry;
      end
    end else if (ctl.rem_go && pre_hit) begin
      entry_nxt = next_entry;
    end
  end

  always_comb begin
    bus_nxt = bus_r;
    if (ctl.bus_load) begin
      bus_nxt = entry_r;
    end else if (ctl.bus_shift) begin
      bus_nxt = next_bus;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    bus_r   <= bus_nxt;
    if (ctl.cmp_en) begin
      take_r  <= take_nxt;
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign take  = take_r;
  assign match = match_r;
  assign bus   = bus_r;

endmodule

// ----- rtl/spl_prefix.sv -----
module spl_prefix #(
  parameter int N = 256
) (
  input  logic [N-1:0] din,
  output logic [N-1:0] dout
);

  localparam int LV = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [0:LV];

  assign lvl[0] = din;

  // log-depth running OR: bit i is set when any bit at or below i is set
  for (genvar l = 0; l < LV; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  assign dout = lvl[LV];

endmodule

// ----- rtl/sorted_priority_list.sv -----
// Sorted priority list: a row of CAPACITY cells holding (handle, tag, prio) in descending
// prio order, cell 0 first. Insert puts the new word ahead of every entry of equal or lower
// prio; on a full list it reports full and changes nothing. Remove drops the first entry whose
// handle and tag both match and closes the gap; without a match it reports not found. Read
// returns the entry at a given rank, or reports rank beyond count. Every result also carries
// the entry count after the operation; the entry fields are zero unless a read succeeded.
// Timing: one word is worked on at a time. Insert, remove and the idle code go from acceptance
// to the result word through accept, compare in every cell and commit. A read at a rank inside
// the list other than the head also passes a shift step, as the entries travel to the head on a
// read-out bus that moves one cell per cycle. The next word is taken as soon as the result is
// handed to the output register; a stalled output register holds the commit until it drains.
`include "sorted_priority_list_macros.svh"

module sorted_priority_list #(
  parameter int CAPACITY = spl_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_opcode,
  input  logic [spl_pkg::HANDLE_W-1:0]     in_handle,
  input  logic signed [spl_pkg::TAG_W-1:0] in_tag,
  input  logic signed [spl_pkg::PRIO_W-1:0] in_prio,
  input  logic [spl_pkg::RANK_W-1:0]       in_rank,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [spl_pkg::HANDLE_W-1:0]     out_handle,
  output logic signed [spl_pkg::TAG_W-1:0] out_tag,
  output logic signed [spl_pkg::PRIO_W-1:0] out_prio,
  output logic [spl_pkg::COUNT_OUT_W-1:0]  out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Sequencer and command word
  spl_pkg::state_t           state_r, state_nxt;
  spl_pkg::op_t              op_r;
  spl_pkg::entry_t           cmd_r;
  logic [spl_pkg::RANK_W-1:0] rank_r;
  logic [spl_pkg::RANK_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;

  // Output register
  logic                             out_valid_r, out_valid_nxt;
  spl_pkg::status_t                 out_status_r, status_nxt;
  spl_pkg::entry_t                  out_entry_r, out_entry_nxt;
  logic [spl_pkg::COUNT_OUT_W-1:0]  out_count_r;

  spl_pkg::cell_ctl_t ctl;

  // Cell row
  spl_pkg::entry_t entry_w [0:CAPACITY-1];
  spl_pkg::entry_t bus_w   [0:CAPACITY-1];
  logic [CAPACITY-1:0] take_w;
  logic [CAPACITY-1:0] match_w;
  logic [CAPACITY-1:0] pre_w;

  logic in_accept;
  logic out_free;
  logic commit;
  logic full;
  logic found;
  logic rank_ok;

  // Hold off the input while reset is asserted so no word is taken and then dropped
  assign in_stall  = !rst_n || (state_r != spl_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == spl_pkg::ST_DONE) && out_free;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign found     = pre_w[CAPACITY-1];
  assign rank_ok   = 32'(rank_r) < 32'(count_r);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    spl_pkg::entry_t prev_e;
    spl_pkg::entry_t next_e;
    spl_pkg::entry_t next_b;
    logic            prev_t;

    if (g == 0) begin : g_head
      assign prev_e = '0;
      assign prev_t = 1'b0;
    end else begin : g_mid
      assign prev_e = entry_w[g-1];
      assign prev_t = take_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_e = '0;
      assign next_b = '0;
    end else begin : g_body
      assign next_e = entry_w[g+1];
      assign next_b = bus_w[g+1];
    end

    spl_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .new_entry  (cmd_r),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .prev_take  (prev_t),
      .pre_hit    (pre_w[g]),
      .next_bus   (next_b),
      .entry      (entry_w[g]),
      .take       (take_w[g]),
      .match      (match_w[g]),
      .bus        (bus_w[g])
    );
  end

  // Running OR of the match flags marks the matching cell and all cells behind it.
  spl_prefix #(
    .N (CAPACITY)
  ) u_prefix (
    .din  (match_w),
    .dout (pre_w)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = spl_pkg::ST_CMP;
        end
      end
      spl_pkg::ST_CMP: begin
        if (op_r == spl_pkg::OP_READ && rank_ok && rank_r != '0) begin
          state_nxt = spl_pkg::ST_SHIFT;
        end else begin
          state_nxt = spl_pkg::ST_DONE;
        end
      end
      spl_pkg::ST_SHIFT: begin
        if (rd_cnt_r == spl_pkg::RANK_W'(1)) begin
          state_nxt = spl_pkg::ST_DONE;
        end
      end
      spl_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = spl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spl_pkg::ST_IDLE;
    endcase
  end

  // Cell control
  always_comb begin
    ctl = '0;
    unique case (state_r)
      spl_pkg::ST_CMP: begin
        ctl.cmp_en   = 1'b1;
        ctl.bus_load = 1'b1;
      end
      spl_pkg::ST_SHIFT: begin
        ctl.bus_shift = 1'b1;
      end
      spl_pkg::ST_DONE: begin
        ctl.ins_go = out_free && (op_r == spl_pkg::OP_INSERT) && !full;
        ctl.rem_go = out_free && (op_r == spl_pkg::OP_REMOVE) && found;
      end
      default: ctl = '0;
    endcase
  end

  // Read-out countdown: one bus shift per cycle until rank reaches the head
  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    if (state_r == spl_pkg::ST_CMP) begin
      rd_cnt_nxt = rank_r;
    end else if (state_r == spl_pkg::ST_SHIFT) begin
      rd_cnt_nxt = rd_cnt_r - spl_pkg::RANK_W'(1);
    end
  end

  // Result word and new count
  always_comb begin
    status_nxt    = spl_pkg::STAT_OK;
    out_entry_nxt = '0;
    count_nxt     = count_r;
    case (op_r)
      spl_pkg::OP_INSERT: begin
        if (full) begin
          status_nxt = spl_pkg::STAT_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      spl_pkg::OP_REMOVE: begin
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = spl_pkg::STAT_MISS;
        end
      end
      spl_pkg::OP_READ: begin
        if (rank_ok) begin
          out_entry_nxt = bus_w[0];
        end else begin
          status_nxt = spl_pkg::STAT_RANGE;
        end
      end
      default: status_nxt = spl_pkg::STAT_OK;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spl_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        count_r <= count_nxt;
      end
    end
  end

  // Hold the command word for the whole operation
  always_ff @(posedge clk) begin
    rd_cnt_r <= rd_cnt_nxt;
    if (in_accept) begin
      op_r         <= spl_pkg::op_t'(in_opcode);
      cmd_r.handle <= in_handle;
      cmd_r.tag    <= in_tag;
      cmd_r.prio   <= in_prio;
      rank_r       <= in_rank;
    end
    if (commit) begin
      out_status_r <= status_nxt;
      out_entry_r  <= out_entry_nxt;
      out_count_r  <= spl_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_handle      = out_entry_r.handle;
  assign out_tag         = out_entry_r.tag;
  assign out_prio        = out_entry_r.prio;
  assign out_entry_count = out_count_r;

  `SPL_ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > CNT_W'(CAPACITY), "count above capacity")
  `SPL_ASSERT(a_ins_grow, clk, rst_n, ctl.ins_go |=> count_r == $past(count_r) + CNT_W'(1), "insert did not grow count")
  `SPL_ASSERT(a_rem_shrink, clk, rst_n, ctl.rem_go |=> count_r == $past(count_r) - CNT_W'(1), "remove did not shrink count")
  `SPL_ASSERT_NEVER(a_take_sorted, clk, rst_n, (state_r == spl_pkg::ST_DONE) && (op_r == spl_pkg::OP_INSERT) && (((take_w << 1) & ~take_w) != '0), "list order broken")
  `SPL_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == spl_pkg::ST_DONE), "result without commit")

endmodule
